// ===== hdl/hsv_to_rgb_converter_macros.svh =====
// Assertion macros for the HSV to RGB converter checker.
// Expects signals clk and arst_n in the scope of use.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication
`define HSVRGB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsv_to_rgb_converter: assertion failed");

// next-cycle implication
`define HSVRGB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsv_to_rgb_converter: assertion failed");

`endif

// ===== hdl/hsvrgb_pkg.sv =====
// Shared constants, types and helpers for the HSV to RGB converter.
// No dependencies.
package hsvrgb_pkg;

	localparam logic [7:0] SECTOR_WIDTH = 8'd43;
	localparam logic [7:0] SECTOR_BASE1 = 8'(1 * 43);
	localparam logic [7:0] SECTOR_BASE2 = 8'(2 * 43);
	localparam logic [7:0] SECTOR_BASE3 = 8'(3 * 43);
	localparam logic [7:0] SECTOR_BASE4 = 8'(4 * 43);
	localparam logic [7:0] SECTOR_BASE5 = 8'(5 * 43);

	localparam logic [2:0] SECTOR_0 = 3'd0;
	localparam logic [2:0] SECTOR_1 = 3'd1;
	localparam logic [2:0] SECTOR_2 = 3'd2;
	localparam logic [2:0] SECTOR_3 = 3'd3;
	localparam logic [2:0] SECTOR_4 = 3'd4;
	localparam logic [2:0] SECTOR_5 = 3'd5;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} hsvrgb_en_t;

	// exact floor(x / 255) for x <= 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

	function automatic logic [2:0] sector_of(input logic [7:0] h);
		logic [2:0] sec;
		if (h >= SECTOR_BASE5) sec = SECTOR_5;
		else if (h >= SECTOR_BASE4) sec = SECTOR_4;
		else if (h >= SECTOR_BASE3) sec = SECTOR_3;
		else if (h >= SECTOR_BASE2) sec = SECTOR_2;
		else if (h >= SECTOR_BASE1) sec = SECTOR_1;
		else sec = SECTOR_0;
		return sec;
	endfunction

	function automatic logic [7:0] sector_base(input logic [2:0] sec);
		logic [7:0] base;
		case (sec)
			SECTOR_1: base = SECTOR_BASE1;
			SECTOR_2: base = SECTOR_BASE2;
			SECTOR_3: base = SECTOR_BASE3;
			SECTOR_4: base = SECTOR_BASE4;
			SECTOR_5: base = SECTOR_BASE5;
			default:  base = 8'd0;
		endcase
		return base;
	endfunction

endpackage

// ===== hdl/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: stream handshake and valid tracking.
// Depends on hsvrgb_pkg and hsvrgb_datapath.
//
// Usage:
//   Input stream s_*: one beat carries hue, saturation and brightness.
//   Output stream m_*: one beat carries red, green and blue, exactly one
//   output beat per input beat, in order.
//   Each beat passes five register stages: sector/offset, three
//   products, divide by 255, two products, divide by 255 and sector
//   routing, the first one loaded at the accepting edge.
//   Throughput is one beat per cycle while the output is not stalled.
//   Each stage advances when it is empty or the stage after it advances,
//   so empty slots are squeezed out; s_tready drops only when all five
//   stages hold beats and m_tready is low. A stall loses or repeats nothing.
//   arst_n clears all valid bits; the block then accepts at once.
module hsv_to_rgb_converter import hsvrgb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // hue[7:0], saturation[15:8], brightness[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // red[7:0], green[15:8], blue[23:16]
);

	hsvrgb_en_t en;
	logic       vld_s1;
	logic       vld_s2;
	logic       vld_s3;
	logic       vld_s4;
	logic       vld_s5;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	always_comb begin
		en.s5 = !vld_s5 || m_tready;
		en.s4 = !vld_s4 || en.s5;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= s_tvalid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
		end
	end

	hsvrgb_datapath u_datapath (
		.clk        (clk),
		.en         (en),
		.hue        (s_tdata[7:0]),
		.saturation (s_tdata[15:8]),
		.brightness (s_tdata[23:16]),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	assign m_tvalid = vld_s5;
	assign m_tdata  = {blue, green, red};

endmodule

// ===== hdl/hsvrgb_datapath.sv =====
// Five-stage arithmetic pipeline of the HSV to RGB converter.
// Depends on hsvrgb_pkg; stage enables come from the top level.
module hsvrgb_datapath import hsvrgb_pkg::*; (
	input  logic       clk,
	input  hsvrgb_en_t en,
	input  logic [7:0] hue,
	input  logic [7:0] saturation,
	input  logic [7:0] brightness,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic [2:0]  sector_c;
	logic [7:0]  rem_c;
	logic [5:0]  rem6_c;
	logic [7:0]  off_c;

	logic [2:0]  sector_s1;
	logic [7:0]  off_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  bri_s1;

	logic [15:0] prod_a_s2;
	logic [15:0] prod_b_s2;
	logic [15:0] prod_p_s2;
	logic [2:0]  sector_s2;
	logic [7:0]  bri_s2;
	logic        grey_s2;

	logic [7:0]  ia_s3;
	logic [7:0]  ib_s3;
	logic [7:0]  p_s3;
	logic [2:0]  sector_s3;
	logic [7:0]  bri_s3;
	logic        grey_s3;

	logic [15:0] prod_q_s4;
	logic [15:0] prod_t_s4;
	logic [7:0]  p_s4;
	logic [2:0]  sector_s4;
	logic [7:0]  bri_s4;
	logic        grey_s4;

	logic [7:0]  q_c;
	logic [7:0]  t_c;
	logic [7:0]  r_c;
	logic [7:0]  g_c;
	logic [7:0]  b_c;

	logic [7:0]  red_s5;
	logic [7:0]  green_s5;
	logic [7:0]  blue_s5;

	// offset within sector, times 6
	always_comb begin
		sector_c = sector_of(hue);
		rem_c    = hue - sector_base(sector_c);
		rem6_c   = rem_c[5:0];
		off_c    = {rem6_c, 2'b00} + {1'b0, rem6_c, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sector_s1 <= sector_c;
			off_s1    <= off_c;
			sat_s1    <= saturation;
			bri_s1    <= brightness;
		end
	end

	// 255 - x taken as an 8-bit complement before widening
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_a_s2 <= sat_s1 * off_s1;
			prod_b_s2 <= sat_s1 * 8'(~off_s1);
			prod_p_s2 <= bri_s1 * 8'(~sat_s1);
			sector_s2 <= sector_s1;
			bri_s2    <= bri_s1;
			grey_s2   <= (sat_s1 == 8'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ia_s3     <= div255(prod_a_s2);
			ib_s3     <= div255(prod_b_s2);
			p_s3      <= div255(prod_p_s2);
			sector_s3 <= sector_s2;
			bri_s3    <= bri_s2;
			grey_s3   <= grey_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_q_s4 <= bri_s3 * 8'(~ia_s3);
			prod_t_s4 <= bri_s3 * 8'(~ib_s3);
			p_s4      <= p_s3;
			sector_s4 <= sector_s3;
			bri_s4    <= bri_s3;
			grey_s4   <= grey_s3;
		end
	end

	always_comb begin
		q_c = div255(prod_q_s4);
		t_c = div255(prod_t_s4);
		case (sector_s4)
			SECTOR_0: begin r_c = bri_s4; g_c = t_c;    b_c = p_s4;   end
			SECTOR_1: begin r_c = q_c;    g_c = bri_s4; b_c = p_s4;   end
			SECTOR_2: begin r_c = p_s4;   g_c = bri_s4; b_c = t_c;    end
			SECTOR_3: begin r_c = p_s4;   g_c = q_c;    b_c = bri_s4; end
			SECTOR_4: begin r_c = t_c;    g_c = p_s4;   b_c = bri_s4; end
			default:  begin r_c = bri_s4; g_c = p_s4;   b_c = q_c;    end
		endcase
		if (grey_s4) begin
			r_c = bri_s4;
			g_c = bri_s4;
			b_c = bri_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			red_s5   <= r_c;
			green_s5 <= g_c;
			blue_s5  <= b_c;
		end
	end

	assign red   = red_s5;
	assign green = green_s5;
	assign blue  = blue_s5;

endmodule

// ===== hdl/hsvrgb_checker.sv =====
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on hsv_to_rgb_converter_macros.svh.
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic s_acc;

	assign s_acc  = s_tvalid && s_tready;

	`HSVRGB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`HSVRGB_ASSERT_IMP(a_ready_free, m_tready || !m_tvalid, s_tready)
	`HSVRGB_ASSERT_NXT(a_latency, s_acc ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready, m_tvalid)

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (.*);
